@@ rtl/core/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_pkg
// Types, opcode and function codes shared by the execute unit modules.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int DATA_WORDS = 32;
    localparam int DIDX_W = $clog2(DATA_WORDS) > 0 ? $clog2(DATA_WORDS) : 1;
    localparam int QDEPTH = 2;
    localparam logic [31:0] PC_RESET = 32'd96;
    localparam logic [31:0] NOP_WORD = 32'h8000_0000;

    localparam logic [4:0] OP_SPECIAL = 5'h00;
    localparam logic [4:0] OP_BLTZ = 5'h01;
    localparam logic [4:0] OP_J = 5'h02;
    localparam logic [4:0] OP_LW = 5'h03;
    localparam logic [4:0] OP_BEQ = 5'h04;
    localparam logic [4:0] OP_ADDI = 5'h08;
    localparam logic [4:0] OP_SW = 5'h0B;
    localparam logic [4:0] OP_MUL = 5'h1C;

    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_JR = 6'h08;
    localparam logic [5:0] FN_MOVZ = 6'h0A;
    localparam logic [5:0] FN_BREAK = 6'h0D;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR = 6'h25;
    localparam logic [5:0] FN_SUB = 6'h22;

    localparam logic [3:0] K_SKIP = 4'd0;
    localparam logic [3:0] K_LOAD = 4'd1;
    localparam logic [3:0] K_NOP = 4'd2;
    localparam logic [3:0] K_ADD = 4'd3;
    localparam logic [3:0] K_AND = 4'd4;
    localparam logic [3:0] K_OR = 4'd5;
    localparam logic [3:0] K_SUB = 4'd6;
    localparam logic [3:0] K_SLL = 4'd7;
    localparam logic [3:0] K_SRL = 4'd8;
    localparam logic [3:0] K_MOVZ = 4'd9;
    localparam logic [3:0] K_JR = 4'd10;
    localparam logic [3:0] K_BRK = 4'd11;
    localparam logic [3:0] K_J = 4'd12;
    localparam logic [3:0] K_ADDI = 4'd13;
    localparam logic [3:0] K_BEQ = 4'd14;
    localparam logic [3:0] K_OTHER = 4'd15;

    // classified request between front and back
    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] sub;      // under K_OTHER: 0 BLTZ, 1 LW, 2 SW, 3 MUL
        logic [31:0] word;
        logic [4:0] load_index;
    } op_t;

    localparam logic [2:0] S_BLTZ = 3'd0;
    localparam logic [2:0] S_LW = 3'd1;
    localparam logic [2:0] S_SW = 3'd2;
    localparam logic [2:0] S_MUL = 3'd3;

    typedef struct packed {
        logic [31:0] next_pc;
        logic halted;
        logic skipped;
        logic reg_written;
        logic [4:0] reg_index;
        logic [31:0] reg_value;
        logic mem_written;
        logic [4:0] mem_index;
        logic mem_fault;
    } res_t;

endpackage

@@ rtl/core/mips_subset_execute_unit.sv @@
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Execute unit for a small MIPS subset with queue-style ports.
// ----------------------------------------------------------------------------
// One request is accepted per cycle (push while full is low) and yields one
// result; the sustained rate is one instruction per cycle while results are
// popped as they appear, set by the single execute stage that reads and writes
// the flop register file and data store. With nothing ahead of it, a request
// passes the two-entry classify queue and then the result register before it
// shows on the result ports, and it can be popped as soon as it shows. Write
// data_base only while the unit is idle.
module mips_subset_execute_unit
    import mse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [31:0] cfg_data,
    input  logic push,
    output logic full,
    input  logic action,
    input  logic [31:0] word,
    input  logic [4:0] load_index,
    output logic empty,
    input  logic pop,
    output logic [31:0] next_pc,
    output logic halted,
    output logic skipped,
    output logic reg_written,
    output logic [4:0] reg_index,
    output logic signed [31:0] reg_value,
    output logic mem_written,
    output logic [4:0] mem_index,
    output logic mem_fault
);
    logic q_valid, q_take, res_valid;
    op_t q_op;
    res_t res;

    // front: classify and queue
    mse_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .word(word), .load_index(load_index), .q_valid(q_valid), .q_op(q_op),
        .q_take(q_take)
    );

    // back: execute and hold the result
    mse_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_op(q_op), .q_take(q_take), .res_valid(res_valid),
        .res(res), .res_take(pop && !empty)
    );

    assign empty = !res_valid;
    assign next_pc = res.next_pc;
    assign halted = res.halted;
    assign skipped = res.skipped;
    assign reg_written = res.reg_written;
    assign reg_index = res.reg_index;
    assign reg_value = signed'(res.reg_value);
    assign mem_written = res.mem_written;
    assign mem_index = res.mem_index;
    assign mem_fault = res.mem_fault;
endmodule

@@ rtl/core/mse_front.sv @@
// ----------------------------------------------------------------------------
// mse_front
// Classify requests by opcode and function into a short queue.
// ----------------------------------------------------------------------------
module mse_front
    import mse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic action,
    input  logic [31:0] word,
    input  logic [4:0] load_index,
    output logic q_valid,
    output op_t q_op,
    input  logic q_take
);
    op_t mem_reg [QDEPTH];
    logic [0:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    op_t cls;
    logic wr;

    always_comb
    begin
        cls.word = word;
        cls.load_index = load_index;
        cls.sub = S_BLTZ;
        cls.kind = K_SKIP;
        if (!action)
            cls.kind = K_LOAD;
        else if (word[31])
        begin
            unique case (word[30:26])
                OP_SPECIAL:
                begin
                    priority if (word[5:0] == FN_ADD) cls.kind = K_ADD;
                    else if (word[5:0] == FN_AND) cls.kind = K_AND;
                    else if (word[5:0] == FN_BREAK) cls.kind = K_BRK;
                    else if (word[5:0] == FN_JR) cls.kind = K_JR;
                    else if (word[5:0] == FN_MOVZ) cls.kind = K_MOVZ;
                    else if (word == NOP_WORD) cls.kind = K_NOP;
                    else if (word[5:0] == FN_OR) cls.kind = K_OR;
                    else if (word[5:0] == FN_SLL) cls.kind = K_SLL;
                    else if (word[5:0] == FN_SRL) cls.kind = K_SRL;
                    else if (word[5:0] == FN_SUB) cls.kind = K_SUB;
                    else cls.kind = K_SKIP;
                end
                OP_J: cls.kind = K_J;
                OP_ADDI: cls.kind = K_ADDI;
                OP_BEQ: cls.kind = K_BEQ;
                OP_BLTZ: begin cls.kind = K_OTHER; cls.sub = S_BLTZ; end
                OP_LW: begin cls.kind = K_OTHER; cls.sub = S_LW; end
                OP_SW: begin cls.kind = K_OTHER; cls.sub = S_SW; end
                OP_MUL: begin cls.kind = K_OTHER; cls.sub = S_MUL; end
                default: cls.kind = K_SKIP;
            endcase
        end
    end

    assign full = (cnt_reg == 2'(QDEPTH));
    assign wr = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op = mem_reg[rp_reg];
    assign wp_next = wr ? wp_reg + 1'b1 : wp_reg;
    assign rp_next = q_take ? rp_reg + 1'b1 : rp_reg;
    assign cnt_next = cnt_reg + 2'(wr) - 2'(q_take);

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ rtl/core/mse_back.sv @@
// ----------------------------------------------------------------------------
// mse_back
// Execute classified requests against registers and data store.
// ----------------------------------------------------------------------------
module mse_back
    import mse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [31:0] cfg_data,
    input  logic q_valid,
    input  op_t q_op,
    output logic q_take,
    output logic res_valid,
    output res_t res,
    input  logic res_take
);
    logic [31:0] rf_reg [32];
    logic [31:0] ds_reg [DATA_WORDS];
    logic [31:0] base_reg, pc_reg;
    logic halt_reg, halt_next;
    logic rv_reg;
    res_t res_reg;
    res_t r;
    logic [31:0] w, a, b, imm, addr, q, pc4, prod;
    logic [4:0] rs, rt, rd;
    logic in_rng, ds_we;
    logic [DIDX_W-1:0] didx, ds_wi;
    logic [31:0] ds_wd;

    assign w = q_op.word;
    assign rs = w[25:21];
    assign rt = w[20:16];
    assign rd = w[15:11];
    assign a = rf_reg[rs];
    assign b = rf_reg[rt];
    assign imm = {{16{w[15]}}, w[15:0]};
    assign addr = a + imm;
    assign q = (addr - base_reg) >> 2;
    assign in_rng = (q < 32'(DATA_WORDS));
    assign didx = q[DIDX_W-1:0];
    assign pc4 = pc_reg + 32'd4;
    assign prod = a * b;
    assign q_take = q_valid && (!rv_reg || res_take);

    always_comb
    begin
        r = '0;
        r.next_pc = pc4;
        halt_next = halt_reg;
        ds_we = 1'b0;
        ds_wi = '0;
        ds_wd = b;
        if (q_op.kind == K_LOAD)
        begin
            r.next_pc = pc_reg;
            if (32'(q_op.load_index) < 32'(DATA_WORDS))
            begin
                ds_we = 1'b1;
                ds_wi = DIDX_W'(q_op.load_index);
                ds_wd = w;
                r.mem_written = 1'b1;
                r.mem_index = q_op.load_index;
            end
            else
                r.mem_fault = 1'b1;
        end
        else if (halt_reg)
            r.next_pc = pc_reg;
        else
        begin
            unique case (q_op.kind)
                K_ADD: begin r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = a + b; end
                K_AND: begin r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = a & b; end
                K_OR: begin r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = a | b; end
                K_SUB: begin r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = a - b; end
                K_SLL:
                begin
                    r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = b << w[10:6];
                end
                K_SRL:
                begin
                    r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = b >> w[10:6];
                end
                K_MOVZ:
                begin
                    if (b == 32'd0)
                    begin
                        r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = a;
                    end
                end
                K_JR: r.next_pc = a;
                K_BRK: halt_next = 1'b1;
                K_J: r.next_pc = {4'b0000, w[25:0], 2'b00};
                K_ADDI: begin r.reg_written = 1'b1; r.reg_index = rt; r.reg_value = addr; end
                K_BEQ: if (a == b) r.next_pc = pc_reg + {imm[29:0], 2'b00};
                K_OTHER:
                begin
                    unique case (q_op.sub)
                        S_BLTZ: if (a[31]) r.next_pc = pc4 + {imm[29:0], 2'b00};
                        S_LW:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rt;
                            r.mem_fault = !in_rng;
                            r.mem_index = in_rng ? 5'(didx) : 5'd0;
                            r.reg_value = in_rng ? ds_reg[didx] : 32'd0;
                        end
                        S_SW:
                        begin
                            r.mem_fault = !in_rng;
                            r.mem_index = in_rng ? 5'(didx) : 5'd0;
                            r.mem_written = in_rng;
                            ds_we = in_rng;
                            ds_wi = didx;
                        end
                        S_MUL:
                        begin
                            r.reg_written = 1'b1; r.reg_index = rd; r.reg_value = prod;
                        end
                        default: r.skipped = 1'b1;
                    endcase
                end
                K_SKIP: r.skipped = 1'b1;
                default: ;
            endcase
        end
        r.halted = halt_next;
    end

    assign res_valid = rv_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            res_reg <= r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_RESET;
            halt_reg <= 1'b0;
            rv_reg <= 1'b0;
            base_reg <= '0;
            for (int i = 0; i < 32; i++) rf_reg[i] <= '0;
            for (int i = 0; i < DATA_WORDS; i++) ds_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                base_reg <= cfg_data;
            if (q_take)
            begin
                pc_reg <= r.next_pc;
                halt_reg <= halt_next;
                if (r.reg_written)
                    rf_reg[r.reg_index] <= r.reg_value;
                if (ds_we)
                    ds_reg[ds_wi] <= ds_wd;
                rv_reg <= 1'b1;
            end
            else if (res_take)
                rv_reg <= 1'b0;
        end
    end
endmodule

@@ rtl/core/mse_checker.sv @@
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module mse_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic halted,
    input logic skipped,
    input logic reg_written,
    input logic mem_written,
    input logic mem_fault
);
    // hold a waiting result until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty) else $error("result dropped");
    // halt never clears once shown on a popped result
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && halted |=> empty || halted) else $error("halt cleared");
    // skipped results carry no side effect
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && skipped |-> !reg_written && !mem_written && !mem_fault)
        else $error("skip with effect");
    // a write and a fault never coexist
    a_mem: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(mem_written && mem_fault)) else $error("write on fault");
    // a request accepted while no result waits is followed by a result on the ports
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && empty |=> ##1 !empty) else $error("result missing");
endmodule

bind mips_subset_execute_unit mse_checker u_chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
    .halted(halted), .skipped(skipped), .reg_written(reg_written),
    .mem_written(mem_written), .mem_fault(mem_fault)
);
